@@ sv/mhpd_pkg.sv @@
package mhpd_pkg;

    // Default sizing of the block
    localparam int CHANNELS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int CHAN_W  = 4;
    localparam int LEVEL_W = 12;
    localparam int MS_W    = 16;
    localparam int TIME_W  = 32;
    localparam int PEAK_W  = 12;

    // Item opcodes
    typedef enum logic [0:0] {
        CMD_SAMPLE  = 1'b0,
        CMD_PROFILE = 1'b1
    } t_cmd;

    // Per-channel hit profile
    typedef struct packed {
        logic [LEVEL_W-1:0] trigger;
        logic [LEVEL_W-1:0] rearm;
        logic [MS_W-1:0]    window;
        logic [MS_W-1:0]    cooldown;
    } t_profile;

endpackage

@@ sv/mhpd_in_if.sv @@
interface mhpd_in_if #(
    parameter int SAMPLE_BITS = mhpd_pkg::SAMPLE_BITS_DEF
);
    import mhpd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [0:0]             cmd;
    logic [CHAN_W-1:0]      channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_W-1:0]      now_ms;
    logic [LEVEL_W-1:0]     trigger_level;
    logic [LEVEL_W-1:0]     rearm_level;
    logic [MS_W-1:0]        window_ms;
    logic [MS_W-1:0]        cooldown_ms;

    modport source (
        output valid, cmd, channel, sample, now_ms,
               trigger_level, rearm_level, window_ms, cooldown_ms,
        input  ready
    );

    modport sink (
        input  valid, cmd, channel, sample, now_ms,
               trigger_level, rearm_level, window_ms, cooldown_ms,
        output ready
    );

endinterface

@@ sv/mhpd_out_if.sv @@
interface mhpd_out_if;
    import mhpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  hit_channel;
    logic [PEAK_W-1:0]  hit_peak;

    modport source (
        output valid, hit_channel, hit_peak,
        input  ready
    );

    modport sink (
        input  valid, hit_channel, hit_peak,
        output ready
    );

endinterface

@@ sv/multichannel_hit_peak_detector.sv @@
// A hit reaches o_out through the input register and then the result register.
// Throughput: one transaction per cycle unless o_out stalls; the per-channel read-modify-write
// of the state registers completes in one compute stage, so a channel may repeat back to back.
// Reset (i_rst_n low, synchronous): input not ready, pipeline empty, all channels idle and
// armed, hit times zero. Channel profiles are not reset and hold no meaning until written.
module multichannel_hit_peak_detector #(
    parameter int CHANNELS    = mhpd_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mhpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mhpd_in_if.sink            i_in,
    mhpd_out_if.source         o_out
);
    import mhpd_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    // Input register
    logic                   r_in_valid;
    logic [0:0]             r_cmd;
    logic [CHAN_W-1:0]      r_channel;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TIME_W-1:0]      r_now;
    t_profile               r_new_prof;

    // Per-channel state
    t_profile               r_profile  [CHANNELS];
    logic [TIME_W-1:0]      r_last_hit [CHANNELS];
    logic [TIME_W-1:0]      r_start    [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_peak     [CHANNELS];
    logic [CHANNELS-1:0]    r_searching;
    logic [CHANNELS-1:0]    r_rearm;

    // Output register
    logic                   r_out_valid;
    logic [CHAN_W-1:0]      r_hit_channel;
    logic [PEAK_W-1:0]      r_hit_peak;

    logic                   fire;
    logic                   in_accept;
    logic                   in_range;
    logic                   is_sample;
    logic [IDX_W-1:0]       idx;
    t_profile               cur_prof;
    logic [CMP_W-1:0]       smp_ext;
    logic [TIME_W-1:0]      since;
    logic [TIME_W-1:0]      elapsed;
    logic [SAMPLE_BITS-1:0] pk;
    logic [CMP_W-1:0]       pk_ext;
    logic                   hit;
    logic                   n_searching;
    logic                   n_rearm;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [TIME_W-1:0]      n_start;
    logic [TIME_W-1:0]      n_last_hit;

    // Handshake: compute stage advances when the result slot is free or draining
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || fire);
    assign in_accept  = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.hit_channel = r_hit_channel;
    assign o_out.hit_peak    = r_hit_peak;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd               <= i_in.cmd;
            r_channel           <= i_in.channel;
            r_sample            <= i_in.sample;
            r_now               <= i_in.now_ms;
            r_new_prof.trigger  <= i_in.trigger_level;
            r_new_prof.rearm    <= i_in.rearm_level;
            r_new_prof.window   <= i_in.window_ms;
            r_new_prof.cooldown <= i_in.cooldown_ms;
        end
    end

    // Channel decode
    assign in_range  = ({1'b0, r_channel} < (CHAN_W + 1)'(CHANNELS));
    assign is_sample = (r_cmd == CMD_SAMPLE);
    assign idx       = r_channel[IDX_W-1:0];
    assign cur_prof  = r_profile[idx];
    assign smp_ext   = CMP_W'(r_sample);
    assign since     = r_now - r_last_hit[idx];
    assign elapsed   = r_now - r_start[idx];
    assign pk        = (r_sample > r_peak[idx]) ? r_sample : r_peak[idx];
    assign pk_ext    = CMP_W'(pk);

    // Per-channel hit state machine step
    always_comb begin
        n_searching = r_searching[idx];
        n_rearm     = r_rearm[idx];
        n_peak      = r_peak[idx];
        n_start     = r_start[idx];
        n_last_hit  = r_last_hit[idx];
        hit         = 1'b0;
        priority if (r_rearm[idx]) begin
            if (smp_ext < CMP_W'(cur_prof.rearm)) begin
                n_rearm = 1'b0;
            end
        end else if (!r_searching[idx]) begin
            if (smp_ext > CMP_W'(cur_prof.trigger) && since > TIME_W'(cur_prof.cooldown)) begin
                n_searching = 1'b1;
                n_start     = r_now;
                n_peak      = r_sample;
            end
        end else begin
            if (elapsed >= TIME_W'(cur_prof.window)) begin
                hit         = 1'b1;
                n_searching = 1'b0;
                n_last_hit  = r_now;
                n_peak      = '0;
                n_rearm     = 1'b1;
            end else begin
                n_peak      = pk;
            end
        end
    end

    // Profile table, undefined until written
    always_ff @(posedge i_clk) begin
        if (fire && in_range && !is_sample) begin
            r_profile[idx] <= r_new_prof;
        end
    end

    // Channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_searching <= '0;
            r_rearm     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last_hit[i] <= '0;
                r_start[i]    <= '0;
                r_peak[i]     <= '0;
            end
        end else if (fire && in_range && is_sample) begin
            r_searching[idx] <= n_searching;
            r_rearm[idx]     <= n_rearm;
            r_peak[idx]      <= n_peak;
            r_start[idx]     <= n_start;
            r_last_hit[idx]  <= n_last_hit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= in_range && is_sample && hit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_hit_channel <= r_channel;
            r_hit_peak    <= pk_ext[PEAK_W-1:0];
        end
    end

endmodule
